// File: src/rnp_pkg.sv
`timescale 1ns / 1ps
// rnp_pkg: shared types and constants of the radix number parser
// no dependencies; used by every other file of the block

package rnp_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_W     = 5;
  localparam int CH_W        = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_BIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_OCT   = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_DEC;

  localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CH_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_B    = 8'h42;
  localparam logic [CH_W-1:0] CH_UP_F    = 8'h46;
  localparam logic [CH_W-1:0] CH_UP_X    = 8'h58;
  localparam logic [CH_W-1:0] CH_LO_A    = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_B    = 8'h62;
  localparam logic [CH_W-1:0] CH_LO_F    = 8'h66;
  localparam logic [CH_W-1:0] CH_LO_X    = 8'h78;
  // offsets that map a letter onto its digit value (A -> 10)
  localparam logic [CH_W-1:0] UP_OFFSET  = CH_UP_A - 8'd10;
  localparam logic [CH_W-1:0] LO_OFFSET  = CH_LO_A - 8'd10;

  // classified character, as held in the queue between front and back
  typedef struct packed {
    logic       is_end;
    logic       blank;
    logic       is_hex;
    logic [3:0] digit;
    logic       minus;
    logic       plus;
    logic       zero;
    logic       letter_b;
    logic       letter_x;
  } cls_t;

endpackage

// File: src/rnp_if.sv
`timescale 1ns / 1ps
// rnp_in_if, rnp_out_if: valid/ready channels of the radix number parser
// depends on rnp_pkg for field widths

interface rnp_in_if;
  logic                       valid;
  logic                       ready;
  logic [rnp_pkg::CH_W-1:0]   ch;
  logic                       is_end;

  modport source (output valid, ch, is_end, input ready);
  modport sink   (input valid, ch, is_end, output ready);
endinterface

interface rnp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rnp_pkg::VALUE_WIDTH-1:0] value;
  logic                                is_valid;

  modport source (output valid, value, is_valid, input ready);
  modport sink   (input valid, value, is_valid, output ready);
endinterface

// File: src/radix_number_parser_top.sv
`timescale 1ns / 1ps
// radix_number_parser_top: top level of the radix number parser
// depends on rnp_pkg, rnp_if, rnp_front and rnp_back

// Parses a number string that arrives one character per item on chars and
// is closed by an item with is_end set; only that end item gives a result
// on results (value and is_valid). Leading whitespace is skipped, radix 2
// and 16 need a 0b/0x prefix in either case, radix 8 a leading 0, radix 10
// takes an optional sign; any other radix gives value 0, is_valid 0. The
// radix register (reset 10) is written through radix_we/radix_wdata; the user
// must write it only while no string is in flight, as the block does not
// enforce this. Throughput is one item per cycle while the queue has room:
// the front end classifies each character as it is accepted and pushes it
// into a two-entry queue, and the back end takes one item per cycle from that
// queue unless an end item waits for room in the result register, doing one
// multiply-add by the radix and a phase update. The result of an end item is
// held in an output register, so chars keeps flowing while a result waits;
// chars stalls only when a second end item waits at the head of the queue
// behind a result not yet taken and the queue behind it has filled.

module radix_number_parser_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        radix_we,
  input  logic [rnp_pkg::RADIX_W-1:0] radix_wdata,
  rnp_in_if.sink                      chars,
  rnp_out_if.source                   results
);

  // queue head handed from front to back
  logic          q_valid;
  rnp_pkg::cls_t q_item;
  logic          q_take;

  // front: accept and classify, two-entry queue
  rnp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  // back: parse state, radix register, result register
  rnp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .radix_we    (radix_we),
    .radix_wdata (radix_wdata),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_take      (q_take),
    .results     (results)
  );

endmodule

// File: src/rnp_front.sv
`timescale 1ns / 1ps
// rnp_front: accepts items, classifies each character, queues the result
// depends on rnp_pkg and rnp_in_if

module rnp_front (
  input  logic          clk,
  input  logic          rst,
  rnp_in_if.sink        chars,
  output logic          q_valid,
  output rnp_pkg::cls_t q_item,
  input  logic          q_take
);

  rnp_pkg::cls_t cls;
  rnp_pkg::cls_t queue [rnp_pkg::QUEUE_DEPTH];
  logic [rnp_pkg::QPTR_W-1:0] wr_ptr;
  logic [rnp_pkg::QPTR_W-1:0] rd_ptr;
  logic [rnp_pkg::QCNT_W-1:0] count;
  logic          push;
  logic [rnp_pkg::CH_W-1:0] up_val;
  logic [rnp_pkg::CH_W-1:0] lo_val;
  logic [rnp_pkg::CH_W-1:0] dec_val;

  // character classes that do not depend on the radix
  always_comb begin
    dec_val      = chars.ch - rnp_pkg::CH_ZERO;
    up_val       = chars.ch - rnp_pkg::UP_OFFSET;
    lo_val       = chars.ch - rnp_pkg::LO_OFFSET;
    cls          = '0;
    cls.is_end   = chars.is_end;
    cls.blank    = (chars.ch == rnp_pkg::CH_SPACE) ||
                   (chars.ch >= rnp_pkg::CH_TAB && chars.ch <= rnp_pkg::CH_CR);
    cls.minus    = (chars.ch == rnp_pkg::CH_MINUS);
    cls.plus     = (chars.ch == rnp_pkg::CH_PLUS);
    cls.zero     = (chars.ch == rnp_pkg::CH_ZERO);
    cls.letter_b = (chars.ch == rnp_pkg::CH_LO_B) || (chars.ch == rnp_pkg::CH_UP_B);
    cls.letter_x = (chars.ch == rnp_pkg::CH_LO_X) || (chars.ch == rnp_pkg::CH_UP_X);
    if (chars.ch >= rnp_pkg::CH_ZERO && chars.ch <= rnp_pkg::CH_NINE) begin
      cls.is_hex = 1'b1;
      cls.digit  = dec_val[3:0];
    end else if (chars.ch >= rnp_pkg::CH_UP_A && chars.ch <= rnp_pkg::CH_UP_F) begin
      cls.is_hex = 1'b1;
      cls.digit  = up_val[3:0];
    end else if (chars.ch >= rnp_pkg::CH_LO_A && chars.ch <= rnp_pkg::CH_LO_F) begin
      cls.is_hex = 1'b1;
      cls.digit  = lo_val[3:0];
    end
  end

  assign chars.ready = (count != rnp_pkg::QCNT_W'(rnp_pkg::QUEUE_DEPTH));
  assign push        = chars.valid && chars.ready;
  assign q_valid     = (count != '0);
  assign q_item      = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == rnp_pkg::QPTR_W'(rnp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + rnp_pkg::QPTR_W'(1);
      end
      if (q_take) begin
        rd_ptr <= (rd_ptr == rnp_pkg::QPTR_W'(rnp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + rnp_pkg::QPTR_W'(1);
      end
      if (push && !q_take) begin
        count <= count + rnp_pkg::QCNT_W'(1);
      end else if (!push && q_take) begin
        count <= count - rnp_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

// File: src/rnp_back.sv
`timescale 1ns / 1ps
// rnp_back: runs the parse state per classified item, holds the radix register
// and the result register; depends on rnp_pkg and rnp_out_if

module rnp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        radix_we,
  input  logic [rnp_pkg::RADIX_W-1:0] radix_wdata,
  input  logic                        q_valid,
  input  rnp_pkg::cls_t               q_item,
  output logic                        q_take,
  rnp_out_if.source                   results
);

  localparam logic [2:0] PH_SPACE  = 3'd0;
  localparam logic [2:0] PH_PREFIX = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_AFTER  = 3'd3;
  localparam logic [2:0] PH_FAIL   = 3'd4;

  logic [rnp_pkg::RADIX_W-1:0]     radix;
  logic [2:0]                      phase;
  logic [2:0]                      phase_next;
  logic [rnp_pkg::VALUE_WIDTH-1:0] accum;
  logic [rnp_pkg::VALUE_WIDTH-1:0] accum_next;
  logic [rnp_pkg::VALUE_WIDTH-1:0] mac;
  logic                            negative;
  logic                            negative_next;
  logic                            seen_digit;
  logic                            seen_digit_next;
  logic                            trailing_junk;
  logic                            trailing_junk_next;
  logic                            digit_ok;
  logic                            out_valid;
  logic [rnp_pkg::VALUE_WIDTH-1:0] out_value;
  logic                            out_ok;

  assign digit_ok = q_item.is_hex && ({1'b0, q_item.digit} < radix);
  assign mac      = accum * rnp_pkg::VALUE_WIDTH'(radix)
                  + rnp_pkg::VALUE_WIDTH'(q_item.digit);

  // an end item waits for room in the result register
  assign q_take = q_valid && (!q_item.is_end || !out_valid || results.ready);

  always_comb begin
    phase_next         = phase;
    accum_next         = accum;
    negative_next      = negative;
    seen_digit_next    = seen_digit;
    trailing_junk_next = trailing_junk;
    case (phase)
      PH_SPACE: begin
        if (!q_item.blank) begin
          if (radix == rnp_pkg::RADIX_DEC) begin
            phase_next = PH_DIGITS;
            if (q_item.minus || q_item.plus) begin
              negative_next = q_item.minus;
            end else if (digit_ok) begin
              accum_next      = mac;
              seen_digit_next = 1'b1;
            end else begin
              trailing_junk_next = 1'b1;
              phase_next         = PH_AFTER;
            end
          end else if (radix == rnp_pkg::RADIX_BIN || radix == rnp_pkg::RADIX_HEX) begin
            phase_next = q_item.zero ? PH_PREFIX : PH_FAIL;
          end else if (radix == rnp_pkg::RADIX_OCT) begin
            phase_next = q_item.zero ? PH_DIGITS : PH_FAIL;
          end else begin
            phase_next = PH_FAIL;
          end
        end
      end
      PH_PREFIX: begin
        if ((radix == rnp_pkg::RADIX_BIN && q_item.letter_b) ||
            (radix == rnp_pkg::RADIX_HEX && q_item.letter_x)) begin
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_DIGITS: begin
        if (digit_ok) begin
          accum_next      = mac;
          seen_digit_next = 1'b1;
        end else begin
          trailing_junk_next = 1'b1;
          phase_next         = PH_AFTER;
        end
      end
      PH_AFTER: begin
        phase_next = PH_AFTER;
      end
      default: begin
        phase_next = PH_FAIL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rnp_pkg::RADIX_RESET;
    end else if (radix_we) begin
      radix <= radix_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SPACE;
      accum         <= '0;
      negative      <= 1'b0;
      seen_digit    <= 1'b0;
      trailing_junk <= 1'b0;
    end else if (q_take) begin
      if (q_item.is_end) begin
        phase         <= PH_SPACE;
        accum         <= '0;
        negative      <= 1'b0;
        seen_digit    <= 1'b0;
        trailing_junk <= 1'b0;
      end else begin
        phase         <= phase_next;
        accum         <= accum_next;
        negative      <= negative_next;
        seen_digit    <= seen_digit_next;
        trailing_junk <= trailing_junk_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_take && q_item.is_end) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take && q_item.is_end) begin
      if (phase == PH_DIGITS || phase == PH_AFTER) begin
        out_value <= negative ? (-accum) : accum;
        out_ok    <= seen_digit && !trailing_junk;
      end else begin
        out_value <= '0;
        out_ok    <= 1'b0;
      end
    end
  end

  assign results.valid    = out_valid;
  assign results.value    = out_value;
  assign results.is_valid = out_ok;

endmodule

// File: src/rnp_checker.sv
`timescale 1ns / 1ps
// rnp_checker: port-level checks of the radix number parser, and its bind
// depends on rnp_pkg and radix_number_parser_top

module rnp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_is_end,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [rnp_pkg::VALUE_WIDTH-1:0] out_value,
  input logic                            out_is_valid
);

  // end items accepted whose result has not been taken
  logic [2:0] pending;
  logic       end_in;
  logic       res_out;

  assign end_in  = in_valid && in_ready && in_is_end;
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else if (end_in && !res_out) begin
      pending <= pending + 3'd1;
    end else if (!end_in && res_out) begin
      pending <= pending - 3'd1;
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_is_valid))
    else $error("result dropped or changed while stalled");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without an accepted end item");

  a_bounded_backlog: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd3)
    else $error("more end items in flight than queue and result register hold");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind radix_number_parser_top rnp_checker u_rnp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (chars.valid),
  .in_ready     (chars.ready),
  .in_is_end    (chars.is_end),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_value    (results.value),
  .out_is_valid (results.is_valid)
);
